>>> hw/rtl/crl_pkg.sv
`default_nettype none
package crl_pkg;

	// Input transaction kinds.
	localparam logic ACT_MAP    = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_STEPPED = 2'd0;
	localparam logic [1:0] REG_PERCENT = 2'd1;
	localparam logic [1:0] REG_MIN     = 2'd2;
	localparam logic [1:0] REG_MAX     = 2'd3;

	// Result of a serial divide: quotient and a valid strobe.
	typedef struct packed {
		logic        done;
		logic [48:0] quot;
	} crl_div_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/crl_stream_if.sv
`default_nettype none
interface crl_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] sample;
	logic [31:0] stop_position;
	logic [31:0] stop_color;
	modport source (output valid, action, sample, stop_position, stop_color, input ready);
	modport sink (input valid, action, sample, stop_position, stop_color, output ready);
endinterface

interface crl_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] color;
	logic [4:0]  stop_total;
	modport source (output valid, color, stop_total, input ready);
	modport sink (input valid, color, stop_total, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/crl_divider.sv
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
// Divides a 49-bit numerator by a 33-bit divisor.
module crl_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [48:0]        num,
	input  wire logic [32:0]        den,
	output crl_pkg::crl_div_res_t   res
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] quot_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [33:0] trial;
	logic [34:0] diff;

	// Shift in the next numerator bit and try a subtraction.
	always_comb begin
		trial = {rem_q[32:0], quot_q[48]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 6'd1;
				busy_q <= (cnt_q != 6'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (!diff[34]) begin
				rem_q  <= diff[33:0];
				quot_q <= {quot_q[47:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[47:0], 1'b0};
			end
		end
	end

	assign res = {done_q, quot_q};
endmodule
`default_nettype wire

>>> hw/rtl/color_ramp_lookup_interp.sv
`default_nettype none
// Colour ramp lookup with piecewise linear interpolation.
// Input channel: each transaction either inserts a colour stop (action 1) or
// maps a sample to a colour (action 0). Output channel: one transaction per
// input, carrying the colour (maps) or the new stop count (inserts, zero when full).
// Stops live in one single-port synchronous memory with registered reads.
// An insert moves each larger stop up one entry, reading it in a read state
// and writing it in a write state, then writes the new stop into the freed
// slot; an insert into a full table is not stored. A map normalises the sample
// with a serial 49-step divider when percent mode is on, scans the stops up and
// then down, then runs a second divide for the blend fraction and four
// sequential byte multiplies; stepped mode and an exact hit skip the fraction
// divide and the blend. One transaction is handled at a time; the result sits
// in an output register, and no input is taken while it waits, so a stalled
// receiver holds the block until the result is taken. The next input can be
// taken in the cycle after that. Reset empties the table at once (the count
// goes to zero) and loads the register defaults; configuration writes go over
// the APB port, and the user must make them only while the block is idle,
// which the block itself does not enforce.
module color_ramp_lookup_interp #(
	parameter int MAX_STOPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	crl_in_if.sink           in_ch,
	crl_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int IW = $clog2(MAX_STOPS);
	localparam int CW = $clog2(MAX_STOPS + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_INS_R = 4'd1;
	localparam logic [3:0] ST_INS_C = 4'd2;
	localparam logic [3:0] ST_NORM  = 4'd3;
	localparam logic [3:0] ST_UP    = 4'd4;
	localparam logic [3:0] ST_DOWN  = 4'd5;
	localparam logic [3:0] ST_RDHI  = 4'd6;
	localparam logic [3:0] ST_FRAC  = 4'd7;
	localparam logic [3:0] ST_BLEND = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_NWAIT = 4'd10;
	localparam logic [3:0] ST_FWAIT = 4'd11;

	// Configuration registers.
	logic        stepped_q, percent_q;
	logic [31:0] min_q, max_q;
	logic        wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stepped_q <= 1'b0;
			percent_q <= 1'b1;
			min_q     <= '0;
			max_q     <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				crl_pkg::REG_STEPPED: stepped_q <= pwdata[0];
				crl_pkg::REG_PERCENT: percent_q <= pwdata[0];
				crl_pkg::REG_MIN:     min_q     <= pwdata;
				crl_pkg::REG_MAX:     max_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			crl_pkg::REG_STEPPED: prdata = {31'd0, stepped_q};
			crl_pkg::REG_PERCENT: prdata = {31'd0, percent_q};
			crl_pkg::REG_MIN:     prdata = min_q;
			default:              prdata = max_q;
		endcase
	end

	// Stop memory: one port, position and colour side by side.
	logic [63:0] mem [MAX_STOPS];
	logic [63:0] rd_q;
	logic [IW-1:0] addr;
	logic          we;
	logic [63:0]   wdata;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	// Control and working registers.
	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] lo_q;
	logic [31:0]   sample_q;
	logic [63:0]   new_q;
	logic [31:0]   p_q;
	logic [63:0]   lo_ent_q;
	logic [31:0]   hi_pos_q;
	logic [31:0]   hi_col_q;
	logic [15:0]   x_q;
	logic [1:0]    byte_q;
	logic [31:0]   color_q;
	logic [4:0]    total_q;
	logic          ovalid_q;
	logic          first_q;

	// Divider shared by normalisation and the blend fraction.
	logic          div_start;
	logic [48:0]   div_num;
	logic [32:0]   div_den;
	logic          div_neg_q;
	crl_pkg::crl_div_res_t div_res;

	crl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// Normalisation operands: magnitudes and sign of the quotient.
	logic signed [32:0] nnum, nden;
	logic [32:0]        nnum_mag, nden_mag;
	logic               nneg;
	always_comb begin
		nnum     = $signed({sample_q[31], sample_q}) - $signed({min_q[31], min_q});
		nden     = $signed({max_q[31], max_q}) - $signed({min_q[31], min_q});
		nnum_mag = nnum[32] ? 33'(-nnum) : 33'(nnum);
		nden_mag = nden[32] ? 33'(-nden) : 33'(nden);
		nneg     = nnum[32] ^ nden[32];
	end

	// Blend fraction operands (hi >= p >= lo here).
	logic [32:0] fnum, fden;
	always_comb begin
		fnum = 33'($signed({p_q[31], p_q}) - $signed({lo_ent_q[63], lo_ent_q[63:32]}));
		fden = 33'($signed({hi_pos_q[31], hi_pos_q})
			- $signed({lo_ent_q[63], lo_ent_q[63:32]}));
	end

	// Signed saturation of the normalised quotient.
	logic [31:0] norm_sat;
	always_comb begin
		if (div_neg_q) begin
			if (div_res.quot > 49'h80000000)
				norm_sat = 32'h80000000;
			else
				norm_sat = 32'(-div_res.quot);
		end else if (div_res.quot > 49'h7FFFFFFF)
			norm_sat = 32'h7FFFFFFF;
		else
			norm_sat = div_res.quot[31:0];
	end

	// One byte of the blend per cycle.
	logic [7:0]  bu, bo, bd, bres;
	logic [23:0] bprod;
	always_comb begin
		bu    = lo_ent_q[8*byte_q +: 8];
		bo    = hi_col_q[8*byte_q +: 8];
		bd    = (bo >= bu) ? (bo - bu) : (bu - bo);
		bprod = x_q * bd;
		bres  = (bo >= bu) ? (bu + bprod[23:16]) : (bu - bprod[23:16]);
	end

	logic in_take;
	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign in_take     = in_ch.valid && in_ch.ready;

	logic [31:0] rd_pos;
	assign rd_pos = rd_q[63:32];

	logic [IW-1:0] last_idx;
	assign last_idx = IW'(count_q - CW'(1));

	// Memory address, write strobe and data, and the divider start and operands.
	always_comb begin
		addr      = idx_q;
		we        = 1'b0;
		wdata     = new_q;
		div_start = 1'b0;
		div_num   = {nnum_mag, 16'd0};
		div_den   = nden_mag;
		case (state_q)
			ST_INS_R: addr = IW'(idx_q - IW'(1));
			ST_INS_C: begin
				if (!first_q && $signed(new_q[63:32]) < $signed(rd_pos)) begin
					we    = 1'b1;
					wdata = rd_q;
				end else begin
					we    = 1'b1;
					wdata = new_q;
				end
			end
			ST_RDHI: addr = lo_q;
			ST_FRAC: begin
				div_start = 1'b1;
				div_num   = {fnum, 16'd0};
				div_den   = fden;
			end
			ST_NORM: div_start = 1'b1;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (in_ch.action == crl_pkg::ACT_INSERT) begin
							if (count_q >= CW'(MAX_STOPS))
								state_q <= ST_OUT;
							else
								state_q <= ST_INS_R;
						end else if (count_q == '0)
							state_q <= ST_OUT;
						else if (percent_q)
							state_q <= ST_NORM;
						else
							state_q <= ST_UP;
					end
				end
				ST_INS_R: begin
					if (idx_q == '0)
						state_q <= ST_INS_C;
					else
						state_q <= ST_INS_C;
				end
				ST_INS_C: begin
					if (!first_q && $signed(new_q[63:32]) < $signed(rd_pos))
						state_q <= ST_INS_R;
					else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_OUT;
					end
				end
				ST_NORM: state_q <= ST_NWAIT;
				ST_NWAIT: if (div_res.done) state_q <= ST_UP;
				ST_UP: begin
					if (!first_q) begin
						if ($signed(rd_pos) < $signed(p_q) && idx_q != last_idx)
							state_q <= ST_UP;
						else
							state_q <= ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (!first_q) begin
						if ($signed(rd_pos) > $signed(p_q) && idx_q != '0)
							state_q <= ST_DOWN;
						else if (idx_q == lo_q || stepped_q)
							state_q <= ST_OUT;
						else
							state_q <= ST_RDHI;
					end
				end
				ST_RDHI: state_q <= ST_FRAC;
				ST_FRAC: state_q <= ST_FWAIT;
				ST_FWAIT: if (div_res.done) state_q <= ST_BLEND;
				ST_BLEND: if (byte_q == 2'd3) state_q <= ST_OUT;
				ST_OUT: begin
					if (!ovalid_q || (out_ch.valid && out_ch.ready)) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Read-wait flag: high in a cycle whose memory read is still in flight.
	// During an insert it marks a zero index, which has no neighbour below.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:  first_q <= 1'b1;
			ST_INS_R: first_q <= (idx_q == '0);
			ST_NWAIT: first_q <= 1'b1;
			ST_UP:    first_q <= !first_q;
			ST_DOWN:  first_q <= !first_q && $signed(rd_pos) > $signed(p_q) && idx_q != '0;
			default:  first_q <= 1'b0;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					sample_q <= in_ch.sample;
					p_q      <= in_ch.sample;
					new_q    <= {in_ch.stop_position, in_ch.stop_color};
					color_q  <= '0;
					if (in_ch.action == crl_pkg::ACT_INSERT) begin
						idx_q <= IW'(count_q);
						if (count_q >= CW'(MAX_STOPS))
							total_q <= '0;
						else
							total_q <= 5'(count_q + CW'(1));
					end else begin
						idx_q   <= '0;
						total_q <= '0;
					end
				end
			end
			ST_INS_C: begin
				if (!first_q && $signed(new_q[63:32]) < $signed(rd_pos))
					idx_q <= IW'(idx_q - IW'(1));
			end
			ST_NORM: div_neg_q <= nneg;
			ST_NWAIT: begin
				if (nden == '0)
					p_q <= '0;
				else if (div_res.done)
					p_q <= norm_sat;
			end
			ST_UP: begin
				if (!first_q) begin
					if ($signed(rd_pos) < $signed(p_q) && idx_q != last_idx)
						idx_q <= IW'(idx_q + IW'(1));
					else begin
						lo_q     <= idx_q;
						hi_pos_q <= rd_pos;
						hi_col_q <= rd_q[31:0];
						lo_ent_q <= rd_q;
					end
				end
			end
			ST_DOWN: begin
				if (!first_q) begin
					lo_ent_q <= rd_q;
					color_q  <= rd_q[31:0];
					if ($signed(rd_pos) > $signed(p_q) && idx_q != '0)
						idx_q <= IW'(idx_q - IW'(1));
					else
						lo_q <= idx_q;
				end
			end
			ST_FRAC: byte_q <= '0;
			ST_FWAIT: begin
				if (div_res.done)
					x_q <= (div_res.quot > 49'hFFFF) ? 16'hFFFF : div_res.quot[15:0];
			end
			ST_BLEND: begin
				color_q[8*byte_q +: 8] <= bres;
				byte_q <= byte_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.color      = color_q;
	assign out_ch.stop_total = total_q;
endmodule
`default_nettype wire
